FILE: sv/itrd_pkg.sv
// Package of shared constants, types and a helper function for the radix digit converter.
package itrd_pkg;

    localparam int VALUE_BITS = 31;
    localparam int RADIX_W    = 5;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 7;
    localparam int BIT_CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int IDX_W      = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [DIGIT_W-1:0] DIGIT_TEN   = DIGIT_W'(10);
    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0]  ASCII_UPPER_A = CHAR_W'(8'h41);

    typedef enum logic [1:0] {
        STAT_DIGIT   = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_BADBASE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT,
        S_SPECIAL
    } state_t;

    // Maps a digit value to its ASCII character, uppercase letters above nine.
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DIGIT_TEN)
        begin
            ch = ASCII_ZERO + CHAR_W'(d);
        end
        else
        begin
            ch = ASCII_UPPER_A + CHAR_W'(d - DIGIT_TEN);
        end
        return ch;
    endfunction

endpackage

FILE: sv/integer_to_radix_digits_top.sv
// Top level of the integer to radix digit converter with its division sequencer.
//
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+----------------------------------
//  config   | wr_en (no wait)          | wr_data[4:0]  radix
//  input    | in_valid / in_ready      | value[30:0]
//  output   | out_valid / out_ready    | digit_char[6:0], status[1:0], last
//
// Each digit comes from one restoring division of the working quotient by the
// radix, one quotient bit per cycle through a single shared compare-subtract
// unit, over all VALUE_BITS (31) bits of the quotient. A value of D digits is
// therefore taken, divided once for each digit and then emitted one digit a
// cycle when the output is not stalled. Zero and invalid-base words skip the
// division and give a single result word. Reset puts the radix at 10 and
// leaves the block idle; a stalled output only holds the emit phase or the
// single word of a zero or invalid-base input, and a new input word is taken
// as soon as the block is idle, even while the final result word still waits
// in the output register.
module integer_to_radix_digits_top
    import itrd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [RADIX_W-1:0]      wr_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [VALUE_BITS-1:0]   value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CHAR_W-1:0]       digit_char,
    output logic [1:0]              status,
    output logic                    last
);

    // Control state.
    state_t                 state_reg, state_next;
    logic [RADIX_W-1:0]     radix_reg;
    logic                   out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [VALUE_BITS-1:0]  quot_reg, quot_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]       digit_cnt_reg, digit_cnt_next;
    logic [IDX_W-1:0]       emit_idx_reg, emit_idx_next;
    status_t                special_reg, special_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    status_t                status_reg, status_next;
    logic                   last_reg, last_next;

    // Digits of the current conversion, least significant first.
    logic [DIGIT_W-1:0]     store [VALUE_BITS];

    // Shared compare-subtract unit signals.
    logic [RADIX_W-1:0]     trial;
    logic                   trial_ge;
    logic [RADIX_W-1:0]     trial_sub;
    logic [VALUE_BITS-1:0]  quot_shift;
    logic                   div_last_bit;
    logic                   quot_zero;
    logic                   store_full;
    logic                   radix_ok;
    logic                   out_load;

    // One step of restoring division: bring down the next dividend bit and
    // subtract the radix when the partial remainder has reached it. The
    // partial remainder is always below the radix, so four bits hold it.
    always_comb
    begin
        trial        = {rem_reg, quot_reg[VALUE_BITS-1]};
        trial_ge     = (trial >= radix_reg);
        trial_sub    = trial_ge ? (trial - radix_reg) : trial;
        quot_shift   = {quot_reg[VALUE_BITS-2:0], trial_ge};
        div_last_bit = (bit_cnt_reg == BIT_CNT_W'(VALUE_BITS - 1));
        quot_zero    = (quot_shift == '0);
        store_full   = (digit_cnt_reg == CNT_W'(VALUE_BITS - 1));
        radix_ok     = radix_reg inside {[RADIX_W'(2):RADIX_W'(10)], RADIX_W'(16)};
        out_load     = !out_valid_reg || out_ready;
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if ((value == '0) || !radix_ok)
                    begin
                        state_next = S_SPECIAL;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_last_bit && (quot_zero || store_full))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_load && (emit_idx_reg == '0))
                begin
                    state_next = S_IDLE;
                end
            end
            S_SPECIAL:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and output logic.
    always_comb
    begin
        in_ready       = (state_reg == S_IDLE);
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        digit_cnt_next = digit_cnt_reg;
        emit_idx_next  = emit_idx_reg;
        special_next   = special_reg;
        char_next      = char_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        out_valid_next = out_load ? 1'b0 : out_valid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    quot_next      = value;
                    rem_next       = '0;
                    bit_cnt_next   = '0;
                    digit_cnt_next = '0;
                    special_next   = (value == '0) ? STAT_EMPTY : STAT_BADBASE;
                end
            end
            S_DIV:
            begin
                quot_next = quot_shift;
                if (div_last_bit)
                begin
                    // The remainder is this digit; start the next division afresh.
                    rem_next       = '0;
                    bit_cnt_next   = '0;
                    digit_cnt_next = digit_cnt_reg + CNT_W'(1);
                    emit_idx_next  = digit_cnt_reg[IDX_W-1:0];
                end
                else
                begin
                    rem_next     = trial_sub[DIGIT_W-1:0];
                    bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                end
            end
            S_EMIT:
            begin
                // The character itself is read from the store in the clocked block.
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STAT_DIGIT;
                    last_next      = (emit_idx_reg == '0);
                    if (emit_idx_reg != '0)
                    begin
                        emit_idx_next = emit_idx_reg - IDX_W'(1);
                    end
                end
            end
            S_SPECIAL:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    char_next      = '0;
                    status_next    = special_reg;
                    last_next      = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radix_reg     <= RADIX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                radix_reg <= wr_data;
            end
        end
    end

    // Datapath registers and the digit store carry no reset. The store is
    // written at the end of each division and read when a digit is emitted.
    always_ff @(posedge clk)
    begin
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        bit_cnt_reg   <= bit_cnt_next;
        digit_cnt_reg <= digit_cnt_next;
        emit_idx_reg  <= emit_idx_next;
        special_reg   <= special_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
        if ((state_reg == S_EMIT) && out_load)
        begin
            char_reg <= digit_to_ascii(store[emit_idx_reg]);
        end
        else
        begin
            char_reg <= char_next;
        end
        if ((state_reg == S_DIV) && div_last_bit)
        begin
            store[digit_cnt_reg[IDX_W-1:0]] <= trial_sub[DIGIT_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign status     = status_reg;
    assign last       = last_reg;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the radix digit converter: a directed table, then random words.
`timescale 1ns / 1ps

module tb;
    import itrd_pkg::*;

    // Bounds of the legal radix settings: 2 to 10 give decimal-style digits, 16 gives hex.
    localparam logic [RADIX_W-1:0] RADIX_LOW = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_HEX = RADIX_W'(16);

    localparam int ITEM_TARGET = 230;   // input words in the whole run
    localparam int CALM_ITEMS  = 30;    // final words sent with no idling on either side
    localparam int SETTLE      = 6;     // cycles left before a radix write once drained
    localparam int TAIL        = 40;    // cycles watched for stray results at the end
    localparam int STALL_LIMIT = 8000;  // cycles with no handshake before giving up
    localparam int N_DIRECTED  = 24;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [RADIX_W-1:0]    wr_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [VALUE_BITS-1:0] value;
    logic                  out_valid;
    logic                  out_ready;
    logic [CHAR_W-1:0]     digit_char;
    logic [1:0]            status;
    logic                  last;

    // One result word as the converter should present it.
    typedef struct packed {
        logic [CHAR_W-1:0] chr;
        status_t           stat;
        logic              is_last;
    } digit_word_t;

    // One row of the directed table. Rows with known_result set carry their single
    // result word typed in; the others are worked out by the digit predictor.
    typedef struct packed {
        logic [RADIX_W-1:0]    rdx;
        logic [VALUE_BITS-1:0] val;
        logic                  known_result;
        logic [CHAR_W-1:0]     chr;
        status_t               stat;
    } conversion_row_t;

    digit_word_t        expected_digits[$];
    logic [RADIX_W-1:0] cur_radix;
    int                 fail_count;
    int                 stall_cycles;
    int                 sent;
    bit                 calm;

    // The first four rows run on the reset radix with no write, so they check that reset left the base at ten.
    // Zero is tested before the base, hence zero under an illegal radix is still empty.
    conversion_row_t directed [N_DIRECTED] = '{
        '{5'd10, 31'd0,          1'b1, 7'h00, STAT_EMPTY},
        '{5'd10, 31'd7,          1'b1, 7'h37, STAT_DIGIT},
        '{5'd10, 31'd1234567890, 1'b0, 7'h00, STAT_DIGIT},
        '{5'd10, 31'h7FFFFFFF,   1'b0, 7'h00, STAT_DIGIT},
        '{5'd2,  31'd1,          1'b1, 7'h31, STAT_DIGIT},
        '{5'd2,  31'h7FFFFFFF,   1'b0, 7'h00, STAT_DIGIT},
        '{5'd2,  31'h40000000,   1'b0, 7'h00, STAT_DIGIT},
        '{5'd2,  31'd0,          1'b1, 7'h00, STAT_EMPTY},
        '{5'd16, 31'd15,         1'b1, 7'h46, STAT_DIGIT},
        '{5'd16, 31'd10,         1'b1, 7'h41, STAT_DIGIT},
        '{5'd16, 31'h7FFFFFFF,   1'b0, 7'h00, STAT_DIGIT},
        '{5'd16, 31'h2BCDEF09,   1'b0, 7'h00, STAT_DIGIT},
        '{5'd3,  31'h7FFFFFFF,   1'b0, 7'h00, STAT_DIGIT},
        '{5'd9,  31'd80,         1'b0, 7'h00, STAT_DIGIT},
        '{5'd0,  31'd5,          1'b1, 7'h00, STAT_BADBASE},
        '{5'd0,  31'd0,          1'b1, 7'h00, STAT_EMPTY},
        '{5'd1,  31'h7FFFFFFF,   1'b1, 7'h00, STAT_BADBASE},
        '{5'd11, 31'd10,         1'b1, 7'h00, STAT_BADBASE},
        '{5'd15, 31'd15,         1'b1, 7'h00, STAT_BADBASE},
        '{5'd17, 31'd1,          1'b1, 7'h00, STAT_BADBASE},
        '{5'd31, 31'h2AAAAAAA,   1'b1, 7'h00, STAT_BADBASE},
        '{5'd31, 31'd0,          1'b1, 7'h00, STAT_EMPTY},
        '{5'd8,  31'h12345678,   1'b0, 7'h00, STAT_DIGIT},
        '{5'd5,  31'd12345,      1'b0, 7'h00, STAT_DIGIT}
    };

    integer_to_radix_digits_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_data    (wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .status     (status),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Works out the result words of one conversion and queues them. The value is
    // divided by the radix until nothing is left; the remainders are then read back
    // from the most significant one, and the final word carries the last flag.
    function automatic void predict_digits(input logic [VALUE_BITS-1:0] v,
                                           input logic [RADIX_W-1:0] rdx);
        logic [DIGIT_W-1:0]    rems [VALUE_BITS];
        logic [VALUE_BITS-1:0] quo;
        int                    n;
        digit_word_t           w;
        if (v == '0)
        begin
            expected_digits.push_back(digit_word_t'{chr: '0, stat: STAT_EMPTY,
                                                    is_last: 1'b1});
        end
        else if (!(rdx == RADIX_HEX || (rdx >= RADIX_LOW && rdx <= RADIX_DEC)))
        begin
            expected_digits.push_back(digit_word_t'{chr: '0, stat: STAT_BADBASE,
                                                    is_last: 1'b1});
        end
        else
        begin
            quo = v;
            n = 0;
            while (quo != '0 && n < VALUE_BITS)
            begin
                rems[n] = DIGIT_W'(quo % rdx);
                quo = quo / rdx;
                n++;
            end
            for (int k = n - 1; k >= 0; k--)
            begin
                w.chr = (rems[k] < DIGIT_TEN) ? ASCII_ZERO + CHAR_W'(rems[k])
                                              : ASCII_UPPER_A + CHAR_W'(rems[k] - DIGIT_TEN);
                w.stat = STAT_DIGIT;
                w.is_last = (k == 0);
                expected_digits.push_back(w);
            end
        end
    endfunction

    // Random values lean towards short conversions, with full-width words, powers of
    // two, zero and the all-ones maximum mixed in so that every value bit toggles.
    function automatic logic [VALUE_BITS-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return VALUE_BITS'($urandom_range(1, 255));
            4, 5:    return VALUE_BITS'($urandom);
            6:       return VALUE_BITS'(1) << $urandom_range(0, VALUE_BITS - 1);
            default: return VALUE_BITS'($urandom_range(1, 65535));
        endcase
    endfunction

    // Mostly legal bases; one phase in five takes any of the 32 settings.
    function automatic logic [RADIX_W-1:0] pick_radix();
        int pick;
        pick = $urandom_range(0, 9);
        if ($urandom_range(0, 4) == 0)
        begin
            return RADIX_W'($urandom_range(0, 31));
        end
        else if (pick == 9)
        begin
            return RADIX_HEX;
        end
        else
        begin
            return RADIX_W'(pick + 2);
        end
    endfunction

    // Presents one input word and returns at the edge where it is taken. Valid is
    // left high so that a following word can go out back to back.
    task automatic push_value(input logic [VALUE_BITS-1:0] v);
        in_valid <= 1'b1;
        value <= v;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    // A random burst of idle cycles on the input side, except in the calm tail.
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Holds the input off until every queued result word has been seen, then lets
    // the block settle so that a radix write lands while it is idle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_digits.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        wr_en <= 1'b1;
        wr_data <= r;
        @(posedge clk);
        wr_en <= 1'b0;
        cur_radix = r;
    endtask

    // Output side: ready drops in short bursts, with longer stretches held high.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Every result word taken is matched against the oldest expectation.
    always @(posedge clk)
    begin
        digit_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_digits.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result word: expected none, %s %h status %0d last %b",
                         $time, "actual char", digit_char, status, last);
            end
            else
            begin
                want = expected_digits.pop_front();
                if (digit_char !== want.chr)
                begin
                    fail_count++;
                    $display("%0t: digit_char mismatch: expected %h, actual %h",
                             $time, want.chr, digit_char);
                end
                if (status !== want.stat)
                begin
                    fail_count++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.stat, status);
                end
                if (last !== want.is_last)
                begin
                    fail_count++;
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.is_last, last);
                end
            end
        end
    end

    // Watchdog: a base-2 conversion of a full-width value has the longest run of
    // division before its first word, so the limit sits well above that run.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || wr_en)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus: the directed table first, then random phases, each phase with a
    // radix of its own written once the previous phase has fully drained.
    initial
    begin
        logic [VALUE_BITS-1:0] v;
        int                    phase_len;
        rst_n <= 1'b0;
        wr_en <= 1'b0;
        wr_data <= '0;
        in_valid <= 1'b0;
        value <= '0;
        cur_radix = RADIX_RESET;
        fail_count = 0;
        stall_cycles = 0;
        sent = 0;
        calm = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (directed[i].rdx != cur_radix)
            begin
                drain_results();
                write_radix(directed[i].rdx);
            end
            push_value(directed[i].val);
            if (directed[i].known_result)
            begin
                expected_digits.push_back(digit_word_t'{chr: directed[i].chr,
                                                        stat: directed[i].stat,
                                                        is_last: 1'b1});
            end
            else
            begin
                predict_digits(directed[i].val, cur_radix);
            end
            sent++;
            sender_gap();
        end

        while (sent < ITEM_TARGET)
        begin
            drain_results();
            write_radix(pick_radix());
            phase_len = $urandom_range(4, 24);
            for (int j = 0; j < phase_len && sent < ITEM_TARGET; j++)
            begin
                calm = (sent >= ITEM_TARGET - CALM_ITEMS);
                v = random_value();
                push_value(v);
                predict_digits(v, cur_radix);
                sent++;
                sender_gap();
            end
        end

        // All words are in; wait for the last results and watch a while for strays.
        in_valid <= 1'b0;
        while (expected_digits.size() != 0) @(posedge clk);
        repeat (TAIL) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/itrd_pkg.sv
sv/integer_to_radix_digits_top.sv
tb/tb.sv
